// ----- rtl/lcd_pkg.sv -----
// Shared types, character codes and command codes for the line command dimmer.
// No dependencies; used by lcd_line and line_command_dimmer.
package lcd_pkg;

  // Characters that matter to the line parser
  localparam logic [7:0] CHAR_LF   = 8'h0A;
  localparam logic [7:0] CHAR_CR   = 8'h0D;
  localparam logic [7:0] CHAR_C    = 8'h43;
  localparam logic [7:0] CHAR_D    = 8'h44;
  localparam logic [7:0] CHAR_E    = 8'h45;
  localparam logic [7:0] CHAR_ZERO = 8'h30;

  localparam logic [6:0] LEVEL_RESET = 7'd100;

  // Code of the command applied by a byte
  localparam logic [1:0] APPLIED_NONE    = 2'd0;
  localparam logic [1:0] APPLIED_SWITCH  = 2'd1;
  localparam logic [1:0] APPLIED_LEVEL_A = 2'd2;
  localparam logic [1:0] APPLIED_LEVEL_B = 2'd3;

  // Command decoded at the end of a line
  typedef struct packed {
    logic [1:0] code;    // APPLIED_*
    logic       sw;      // switch value for a switch command
    logic [7:0] value;   // parsed hex value for a level command
  } lcd_cmd_t;

  // Bit 4 set when the character is a hex digit; bits 3:0 hold its value.
  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, 4'(c - 8'h30)};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      r = {1'b1, 4'(c - 8'h61 + 8'd10)};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r = {1'b1, 4'(c - 8'h41 + 8'd10)};
    end
    return r;
  endfunction

endpackage

// ----- rtl/lcd_line.sv -----
// Line assembler and command decoder: collects bytes into a line, parses hex.
// Depends on lcd_pkg.
module lcd_line import lcd_pkg::*; #(
  parameter int LINE_LENGTH = 64
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       step,
  input  logic [7:0] rx_char,
  output lcd_cmd_t   cmd
);

  localparam int CW = $clog2(LINE_LENGTH);
  localparam logic [CW-1:0] FULL_COUNT = CW'(LINE_LENGTH - 1);

  logic [CW-1:0] line_count;
  logic [7:0]    lead_char;
  logic [7:0]    second_char;
  logic [7:0]    hex_value;
  logic          hex_stopped;

  logic          term;
  logic [4:0]    digit;

  assign term  = (rx_char == CHAR_LF) || (rx_char == CHAR_CR) || (line_count >= FULL_COUNT);
  assign digit = hex_digit(rx_char);

  always_comb begin
    cmd.code  = APPLIED_NONE;
    cmd.sw    = (second_char != CHAR_ZERO);
    cmd.value = hex_value;
    if (term) begin
      if (line_count == CW'(2) && lead_char == CHAR_C) begin
        cmd.code = APPLIED_SWITCH;
      end else if (line_count > CW'(1) && lead_char == CHAR_D) begin
        cmd.code = APPLIED_LEVEL_A;
      end else if (line_count > CW'(1) && lead_char == CHAR_E) begin
        cmd.code = APPLIED_LEVEL_B;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      line_count  <= '0;
      hex_value   <= '0;
      hex_stopped <= 1'b0;
    end else if (step) begin
      if (term) begin
        line_count  <= '0;
        hex_value   <= '0;
        hex_stopped <= 1'b0;
      end else begin
        line_count <= line_count + CW'(1);
        if (line_count == '0) begin
          hex_value   <= '0;
          hex_stopped <= 1'b0;
        end else if (!hex_stopped) begin
          if (!digit[4]) begin
            hex_stopped <= 1'b1;
          end else begin
            hex_value <= {hex_value[3:0], digit[3:0]};
          end
        end
      end
    end
  end

  // Character slots: written before they are read within a line
  always_ff @(posedge clk) begin
    if (step && !term) begin
      if (line_count == '0) begin
        lead_char <= rx_char;
      end
      if (line_count == CW'(1)) begin
        second_char <= rx_char;
      end
    end
  end

endmodule

// ----- rtl/line_command_dimmer.sv -----
// Top level of the line command dimmer: handshakes, switch and level state, results.
// Depends on lcd_pkg and lcd_line.
//
//   channel  | handshake             | payload
//   ---------+-----------------------+---------------------------------------------
//   rx       | rx_valid / rx_ready   | rx_byte
//   res      | res_valid / res_ready | pwm_a, pwm_b, switch_on, level_a, level_b,
//            |                       | applied
//   cfg      | cfg_valid / cfg_ready | cfg_data (level limit, 7 bits)
//
// One byte per cycle sustained while results are taken; each byte goes from the input
// register, loaded at its transaction, to the result register when that is free.
// Synchronous reset: switch on, both levels and the limit at 100, line empty.
// A stalled result holds the result register; the input register still takes a
// byte while it is empty, so rx stalls only when both registers are full.
// cfg_ready is always high; the user must change the limit only while idle (not enforced).
module line_command_dimmer import lcd_pkg::*; #(
  parameter int LINE_LENGTH = 64
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       rx_valid,
  output logic       rx_ready,
  input  logic [7:0] rx_byte,
  output logic       res_valid,
  input  logic       res_ready,
  output logic [7:0] pwm_a,
  output logic [7:0] pwm_b,
  output logic       switch_on,
  output logic [6:0] level_a,
  output logic [6:0] level_b,
  output logic [1:0] applied,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [6:0] cfg_data
);

  // Input register
  logic       in_full;
  logic [7:0] in_byte;

  // Configuration and persistent state
  logic [6:0] limit;
  logic       switch_state;
  logic [6:0] level_store_a;
  logic [6:0] level_store_b;

  logic       switch_next;
  logic [6:0] level_a_next;
  logic [6:0] level_b_next;
  logic [6:0] clamped;

  logic       advance;   // result register free for a new byte
  logic       step;      // buffered byte is processed this cycle
  lcd_cmd_t   cmd;

  assign advance   = !res_valid || res_ready;
  assign step      = in_full && advance;
  assign rx_ready  = !in_full || advance;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (rx_ready) begin
      in_full <= rx_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rx_valid && rx_ready) begin
      in_byte <= rx_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      limit <= LEVEL_RESET;
    end else if (cfg_valid && cfg_ready) begin
      limit <= cfg_data;
    end
  end

  lcd_line #(
    .LINE_LENGTH(LINE_LENGTH)
  ) u_line (
    .clk     (clk),
    .rst     (rst),
    .step    (step),
    .rx_char (in_byte),
    .cmd     (cmd)
  );

  // Clamp the parsed value to the configured limit
  assign clamped = (cmd.value > {1'b0, limit}) ? limit : cmd.value[6:0];

  always_comb begin
    switch_next  = switch_state;
    level_a_next = level_store_a;
    level_b_next = level_store_b;
    case (cmd.code)
      APPLIED_SWITCH:  switch_next  = cmd.sw;
      APPLIED_LEVEL_A: level_a_next = clamped;
      APPLIED_LEVEL_B: level_b_next = clamped;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      switch_state  <= 1'b1;
      level_store_a <= LEVEL_RESET;
      level_store_b <= LEVEL_RESET;
      res_valid     <= 1'b0;
    end else begin
      if (step) begin
        switch_state  <= switch_next;
        level_store_a <= level_a_next;
        level_store_b <= level_b_next;
        res_valid     <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  // Result register: state after the byte, PWM compare is level doubled or zero when off
  always_ff @(posedge clk) begin
    if (step) begin
      pwm_a     <= switch_next ? {level_a_next, 1'b0} : 8'd0;
      pwm_b     <= switch_next ? {level_b_next, 1'b0} : 8'd0;
      switch_on <= switch_next;
      level_a   <= level_a_next;
      level_b   <= level_b_next;
      applied   <= cmd.code;
    end
  end

endmodule
